// File: hw/rtl/prle_pkg.sv
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and constants of the palette run-length pixel encoder.
// ----------------------------------------------------------------------------
package prle_pkg;

  localparam logic OpEncode = 1'b0;
  localparam logic OpRead   = 1'b1;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ColorW = 32;
  localparam int unsigned FillW  = 5;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] RunMax = 5'd16;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [CodeW-1:0]  code_byte;
    logic              code_valid;
    logic              image_done;
    logic              overflow;
    logic [ColorW-1:0] entry_color;
    logic [FillW-1:0]  entries_used;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

// File: hw/rtl/palette_rle_pixel_encoder.sv
// ----------------------------------------------------------------------------
// palette_rle_pixel_encoder
// Maps ARGB pixels to palette indices and emits 4-bit run-length code bytes.
// ----------------------------------------------------------------------------
// Each accepted item yields one or two results. The front end classifies a
// pixel in the cycle it is accepted (parallel compare against the palette,
// append, run update) and pushes its results into a four-deep queue; the
// back end presents them one per unstalled cycle from an output register. An
// item is accepted in any cycle where the queue has room for two records, so
// the input sustains one item per cycle while the output keeps up and slows
// to the output's pace, one result per cycle, when items cause two results.
module palette_rle_pixel_encoder #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] pixel_argb_i,
  input  logic        end_of_image_i,
  input  logic [3:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        code_valid_o,
  output logic        image_done_o,
  output logic        overflow_o,
  output logic [31:0] entry_color_o,
  output logic [4:0]  entries_used_o,
  output logic        last_result_o
);

  prle_pkg::push_t   push;
  prle_pkg::result_t head;
  prle_pkg::result_t res;
  logic              nonempty;
  logic              room;
  logic              pop;
  logic              accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  prle_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .pixel_argb_i   (pixel_argb_i),
    .end_of_image_i (end_of_image_i),
    .entry_index_i  (entry_index_i),
    .push_o         (push)
  );

  prle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .room_o     (room)
  );

  prle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .nonempty_i  (nonempty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign code_byte_o    = res.code_byte;
  assign code_valid_o   = res.code_valid;
  assign image_done_o   = res.image_done;
  assign overflow_o     = res.overflow;
  assign entry_color_o  = res.entry_color;
  assign entries_used_o = res.entries_used;
  assign last_result_o  = res.last_result;

endmodule

// File: hw/rtl/prle_front.sv
// ----------------------------------------------------------------------------
// prle_front
// Palette lookup, palette append and run tracking; emits one or two result
// records per accepted item.
// ----------------------------------------------------------------------------
module prle_front #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic [prle_pkg::ColorW-1:0]  pixel_argb_i,
  input  logic                         end_of_image_i,
  input  logic [prle_pkg::IdxW-1:0]    entry_index_i,
  output prle_pkg::push_t              push_o
);

  localparam int unsigned TabIdxW = $clog2(PALETTE_ENTRIES);
  localparam logic [prle_pkg::FillW-1:0] FillMax = prle_pkg::FillW'(PALETTE_ENTRIES);

  logic [prle_pkg::ColorW-1:0] table_q [PALETTE_ENTRIES];
  logic [prle_pkg::FillW-1:0]  fill_q, fill_d;
  logic [prle_pkg::IdxW-1:0]   run_idx_q, run_idx_d;
  logic                        run_act_q, run_act_d;
  logic [prle_pkg::CountW-1:0] run_cnt_q, run_cnt_d;
  logic                        ovf_q, ovf_d;

  logic                        hit;
  logic [prle_pkg::IdxW-1:0]   hit_idx;
  logic                        room;
  logic [prle_pkg::IdxW-1:0]   pix_idx;
  logic                        tab_we;
  logic [prle_pkg::ColorW-1:0] rd_color;
  logic [prle_pkg::CodeW-1:0]  code_a, code_b;
  logic                        done_a, done_b;
  logic [1:0]                  nc;
  logic                        act_m;
  logic [prle_pkg::CountW-1:0] cnt_m;
  logic                        emit;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = PALETTE_ENTRIES - 1; i >= 0; i--) begin
      if ((prle_pkg::FillW'(i) < fill_q) && (table_q[i] == pixel_argb_i)) begin
        hit     = 1'b1;
        hit_idx = prle_pkg::IdxW'(i);
      end
    end
  end

  assign room    = fill_q < FillMax;
  assign pix_idx = hit ? hit_idx : fill_q[prle_pkg::IdxW-1:0];
  assign rd_color = ({1'b0, entry_index_i} < fill_q) ?
                    table_q[entry_index_i[TabIdxW-1:0]] : '0;

  always_comb begin
    fill_d    = fill_q;
    run_idx_d = run_idx_q;
    run_act_d = run_act_q;
    run_cnt_d = run_cnt_q;
    ovf_d     = ovf_q;
    tab_we    = 1'b0;
    code_a    = '0;
    code_b    = '0;
    done_a    = 1'b0;
    done_b    = 1'b0;
    nc        = 2'd0;
    act_m     = run_act_q;
    cnt_m     = run_cnt_q;
    emit      = 1'b0;
    push_o    = '0;
    if (accept_i) begin
      push_o.v0 = 1'b1;
      if (op_i == prle_pkg::OpRead) begin
        push_o.r0.entry_color = rd_color;
      end else if (ovf_q) begin
        emit = 1'b0;
      end else if (!hit && !room) begin
        ovf_d     = 1'b1;
        run_act_d = 1'b0;
        run_cnt_d = '0;
      end else begin
        emit = 1'b1;
        if (!hit) begin
          tab_we = 1'b1;
          fill_d = fill_q + 1'b1;
        end
        if (run_act_q && (run_idx_q == pix_idx)) begin
          cnt_m = run_cnt_q + 1'b1;
          if (cnt_m >= prle_pkg::RunMax) begin
            code_a = {4'hF, pix_idx};
            done_a = end_of_image_i;
            nc     = 2'd1;
            act_m  = 1'b0;
            cnt_m  = '0;
          end
        end else begin
          if (run_act_q) begin
            code_a = {4'(run_cnt_q - 1'b1), run_idx_q};
            nc     = 2'd1;
          end
          run_idx_d = pix_idx;
          act_m     = 1'b1;
          cnt_m     = 5'd1;
        end
        if (end_of_image_i && act_m) begin
          if (nc == 2'd0) begin
            code_a = {4'(cnt_m - 1'b1), pix_idx};
            done_a = 1'b1;
          end else begin
            code_b = {4'(cnt_m - 1'b1), pix_idx};
            done_b = 1'b1;
          end
          nc    = nc + 2'd1;
          act_m = 1'b0;
          cnt_m = '0;
        end
        run_act_d = act_m;
        run_cnt_d = cnt_m;
      end
      if (emit && (nc != 2'd0)) begin
        push_o.r0.code_byte  = code_a;
        push_o.r0.code_valid = 1'b1;
        push_o.r0.image_done = done_a;
      end
      push_o.r0.last_result = !(emit && (nc == 2'd2));
      push_o.v1             = emit && (nc == 2'd2);
      push_o.r1.code_byte   = code_b;
      push_o.r1.code_valid  = 1'b1;
      push_o.r1.image_done  = done_b;
      push_o.r1.last_result = 1'b1;
    end
    push_o.r0.overflow     = ovf_d;
    push_o.r0.entries_used = fill_d;
    push_o.r1.overflow     = ovf_d;
    push_o.r1.entries_used = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      run_idx_q <= '0;
      run_act_q <= 1'b0;
      run_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      run_idx_q <= run_idx_d;
      run_act_q <= run_act_d;
      run_cnt_q <= run_cnt_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      table_q[fill_q[TabIdxW-1:0]] <= pixel_argb_i;
    end
  end

endmodule

// File: hw/rtl/prle_queue.sv
// ----------------------------------------------------------------------------
// prle_queue
// Small result queue between front and back; takes up to two records per
// cycle and hands out one.
// ----------------------------------------------------------------------------
module prle_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prle_pkg::push_t   push_i,
  input  logic              pop_i,
  output prle_pkg::result_t head_o,
  output logic              nonempty_o,
  output logic              room_o
);

  prle_pkg::result_t              mem_q [prle_pkg::QDepth];
  logic [prle_pkg::QPtrW-1:0]     wr_q, wr_d;
  logic [prle_pkg::QPtrW-1:0]     rd_q, rd_d;
  logic [prle_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic [prle_pkg::QPtrW-1:0]     wr_nxt;

  assign wr_nxt     = wr_q + 1'b1;
  assign head_o     = mem_q[rd_q];
  assign nonempty_o = cnt_q != '0;
  assign room_o     = cnt_q <= prle_pkg::QCntW'(prle_pkg::QDepth - 2);

  always_comb begin
    wr_d  = wr_q + prle_pkg::QPtrW'(push_i.v0) + prle_pkg::QPtrW'(push_i.v1);
    rd_d  = rd_q + prle_pkg::QPtrW'(pop_i);
    cnt_d = cnt_q + prle_pkg::QCntW'(push_i.v0) + prle_pkg::QCntW'(push_i.v1)
            - prle_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

endmodule

// File: hw/rtl/prle_back.sv
// ----------------------------------------------------------------------------
// prle_back
// Output register; drains the result queue one record per transfer.
// ----------------------------------------------------------------------------
module prle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prle_pkg::result_t head_i,
  input  logic              nonempty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prle_pkg::result_t out_o
);

  logic              vld_q, vld_d;
  prle_pkg::result_t res_q;

  assign pop_o       = nonempty_i && (!vld_q || !out_stall_i);
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= head_i;
    end
  end

endmodule

// File: dv/palette_rle_pixel_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_rle_pixel_encoder_tb
// Self-checking bench for the palette run-length pixel encoder.
// ----------------------------------------------------------------------------
// Sends ARGB pixels and palette reads through the valid/stall input channel.
// A model in this bench tracks the palette, the open run and the overflow
// flag, and queues the code or status records that each transfer should
// produce. A monitor compares every output transfer with the oldest queued
// record. Traffic covers:
//   - directed runs and reads
//   - random images built from runs of varied length
//   - a drain pause
//   - palette overflow at the end
// Both channels stall at random, except during one stretch with no idling.
// ----------------------------------------------------------------------------
module palette_rle_pixel_encoder_tb;

  localparam int unsigned PaletteEntries = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = prle_pkg::OpEncode;
  logic [31:0] pixel_argb_i = '0;
  logic        end_of_image_i = 1'b0;
  logic [3:0]  entry_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  code_byte_o;
  logic        code_valid_o;
  logic        image_done_o;
  logic        overflow_o;
  logic [31:0] entry_color_o;
  logic [4:0]  entries_used_o;
  logic        last_result_o;

  // Model state
  logic [31:0] palette_colors [PaletteEntries];
  logic [4:0]  palette_fill = '0;
  logic [3:0]  run_index = '0;
  logic        run_active = 1'b0;
  logic [4:0]  run_count = '0;
  logic        overflow_seen = 1'b0;

  prle_pkg::result_t pending_results[$];

  bit idle_on = 1'b1;
  int errors = 0;
  int pixels_sent = 0;
  int reads_sent = 0;
  int codes_seen = 0;
  int full_runs_seen = 0;
  int images_closed = 0;

  palette_rle_pixel_encoder #(
    .PALETTE_ENTRIES(PaletteEntries)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .pixel_argb_i,
    .end_of_image_i,
    .entry_index_i,
    .out_valid_o,
    .out_stall_i,
    .code_byte_o,
    .code_valid_o,
    .image_done_o,
    .overflow_o,
    .entry_color_o,
    .entries_used_o,
    .last_result_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 11);
  end

  function automatic void push_result(logic [7:0] code, logic valid, logic done,
                                      logic [31:0] color, logic last);
    prle_pkg::result_t res;
    res.code_byte    = code;
    res.code_valid   = valid;
    res.image_done   = done;
    res.overflow     = overflow_seen;
    res.entry_color  = color;
    res.entries_used = palette_fill;
    res.last_result  = last;
    pending_results.push_back(res);
  endfunction

  function automatic bit palette_has(logic [31:0] color);
    for (int i = 0; i < int'(palette_fill); i++) begin
      if (palette_colors[i] == color) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] open_run_code();
    logic [4:0] len_m1;
    len_m1 = run_count - 5'd1;
    return {len_m1[3:0], run_index};
  endfunction

  // Queue the records one accepted item produces and advance the model.
  function automatic void predict_codes(logic op, logic [31:0] pix, logic eoi,
                                        logic [3:0] sel);
    logic [7:0] codes [2];
    logic       dones [2];
    int         n;
    logic [3:0] idx;
    bit         found;
    n = 0;
    idx = '0;
    found = 1'b0;
    if (op == prle_pkg::OpRead) begin
      push_result('0, 1'b0, 1'b0,
                  ({1'b0, sel} < palette_fill) ? palette_colors[sel] : '0, 1'b1);
      return;
    end
    if (overflow_seen) begin
      push_result('0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < int'(palette_fill); i++) begin
      if (!found && palette_colors[i] == pix) begin
        idx = i[3:0];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (palette_fill < 5'(PaletteEntries)) begin
        idx = palette_fill[3:0];
        palette_colors[palette_fill[3:0]] = pix;
        palette_fill++;
      end else begin
        overflow_seen = 1'b1;
        run_active = 1'b0;
        run_count = '0;
        push_result('0, 1'b0, 1'b0, '0, 1'b1);
        return;
      end
    end
    if (run_active && run_index == idx) begin
      run_count++;
      if (run_count >= prle_pkg::RunMax) begin
        codes[n] = open_run_code();
        dones[n] = eoi;
        n++;
        run_active = 1'b0;
        run_count = '0;
      end
    end else begin
      if (run_active) begin
        codes[n] = open_run_code();
        dones[n] = 1'b0;
        n++;
      end
      run_index = idx;
      run_active = 1'b1;
      run_count = 5'd1;
    end
    if (eoi && run_active) begin
      codes[n] = open_run_code();
      dones[n] = 1'b1;
      n++;
      run_active = 1'b0;
      run_count = '0;
    end
    if (n == 0) begin
      push_result('0, 1'b0, 1'b0, '0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        push_result(codes[i], 1'b1, dones[i], '0, (i == n - 1));
      end
    end
  endfunction

  function automatic logic [31:0] fresh_color();
    logic [31:0] color;
    color = $urandom;
    while (palette_has(color)) color = $urandom;
    return color;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
    end
  endfunction

  always @(posedge clk_i) begin
    prle_pkg::result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got code %0h color %0h",
                 $time, code_byte_o, entry_color_o);
      end else begin
        exp = pending_results.pop_front();
        check_field("code_byte", 32'(exp.code_byte), 32'(code_byte_o));
        check_field("code_valid", 32'(exp.code_valid), 32'(code_valid_o));
        check_field("image_done", 32'(exp.image_done), 32'(image_done_o));
        check_field("overflow", 32'(exp.overflow), 32'(overflow_o));
        check_field("entry_color", exp.entry_color, entry_color_o);
        check_field("entries_used", 32'(exp.entries_used), 32'(entries_used_o));
        check_field("last_result", 32'(exp.last_result), 32'(last_result_o));
        if (code_valid_o) begin
          codes_seen++;
          if (code_byte_o[7:4] == 4'hf) full_runs_seen++;
          if (image_done_o) images_closed++;
        end
      end
    end
  end

  // Drive one item from a falling edge and hold it until the transfer.
  task automatic send_item(logic op, logic [31:0] pix, logic eoi, logic [3:0] sel);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    pixel_argb_i = pix;
    end_of_image_i = eoi;
    entry_index_i = sel;
    do @(posedge clk_i); while (in_stall_o);
    predict_codes(op, pix, eoi, sel);
    if (op == prle_pkg::OpRead) reads_sent++;
    else pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [31:0] pix, logic eoi);
    send_item(prle_pkg::OpEncode, pix, eoi, 4'($urandom));
  endtask

  task automatic send_read(logic [3:0] sel);
    send_item(prle_pkg::OpRead, $urandom, 1'($urandom), sel);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_reset_reads();
    send_item(prle_pkg::OpRead, 32'hffff_ffff, 1'b1, 4'd0);
    send_item(prle_pkg::OpRead, 32'h0000_0000, 1'b0, 4'd15);
  endtask

  task automatic test_directed_runs();
    // single-pixel image
    send_pixel(32'h0000_0000, 1'b1);
    // full run closed by end of image
    for (int i = 0; i < 16; i++) send_pixel(32'hffff_ffff, i == 15);
    // color change and end of image on the same pixel
    send_pixel(32'hff00_0000, 1'b0);
    send_pixel(32'h00ff_0000, 1'b1);
    // reads inside an open run
    send_pixel(32'h0000_ff00, 1'b0);
    send_read(4'd3);
    send_read(4'd15);
    send_pixel(32'h0000_ff00, 1'b1);
  endtask

  task automatic test_random_images(int item_count);
    int          sent;
    int          runs;
    int          len;
    logic [31:0] color;
    logic        eoi;
    sent = 0;
    while (sent < item_count) begin
      runs = $urandom_range(6, 1);
      for (int r = 0; r < runs; r++) begin
        if (palette_fill < 5'(PaletteEntries) && $urandom_range(99) < 10) begin
          color = fresh_color();
        end else begin
          color = palette_colors[4'($urandom_range(palette_fill - 1))];
        end
        case ($urandom_range(9))
          6, 7: len = $urandom_range(17, 15);
          8: len = $urandom_range(34, 30);
          9: len = $urandom_range(12, 5);
          default: len = $urandom_range(4, 1);
        endcase
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 8) begin
            send_read(4'($urandom));
            sent++;
          end
          eoi = (r == runs - 1 && k == len - 1) || ($urandom_range(99) < 2);
          send_pixel(color, eoi);
          sent++;
        end
      end
    end
  endtask

  task automatic test_idle_free_stretch();
    idle_on = 1'b0;
    test_random_images(400);
    idle_on = 1'b1;
  endtask

  task automatic test_overflow();
    while (palette_fill < 5'(PaletteEntries)) send_pixel(fresh_color(), 1'b0);
    send_pixel(palette_colors[5], 1'b0);
    send_pixel(palette_colors[5], 1'b0);
    // seventeenth color with end of image: drop run, ignore flag
    send_pixel(fresh_color(), 1'b1);
    for (int i = 0; i < 16; i++) begin
      send_read(i[3:0]);
      if ($urandom_range(1)) begin
        send_pixel(palette_colors[4'($urandom_range(15))], 1'($urandom));
      end else begin
        send_pixel($urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < PaletteEntries; i++) palette_colors[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_reads();
    test_directed_runs();
    test_random_images(400);
    test_idle_free_stretch();
    wait_drained();
    test_random_images(700);
    test_overflow();

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("covered %0d pixels and %0d palette reads; %0d run codes, %0d full runs,",
             pixels_sent, reads_sent, codes_seen, full_runs_seen);
    $display("%0d images closed, palette at %0d entries, overflow flag %0b",
             images_closed, palette_fill, overflow_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: palette_rle_pixel_encoder.f
hw/rtl/prle_pkg.sv
hw/rtl/prle_front.sv
hw/rtl/prle_queue.sv
hw/rtl/prle_back.sv
hw/rtl/palette_rle_pixel_encoder.sv
dv/palette_rle_pixel_encoder_tb.sv
